// ===== src/rwvd_pkg.sv =====
package rwvd_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 2;

  // input type codes
  localparam logic [2:0] TYPE_U16 = 3'd0;
  localparam logic [2:0] TYPE_S16 = 3'd1;
  localparam logic [2:0] TYPE_U32 = 3'd2;
  localparam logic [2:0] TYPE_S32 = 3'd3;
  localparam logic [2:0] TYPE_F32 = 3'd4;
  localparam logic [2:0] TYPE_F64 = 3'd5;

  localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;

  // decoded request handed from front to back
  typedef struct packed {
    logic [63:0] value_bits;
    logic        err;
    logic        scale_enable;
    logic [63:0] scale_bits;
  } rwvd_item_t;

  // queue status seen by the top level
  typedef struct packed {
    logic [7:0] count;
    logic       full;
    logic       empty;
  } rwvd_q_stat_t;

  // leading zero count of a 32-bit word (32 when zero)
  function automatic logic [5:0] lzc32(logic [31:0] x);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) n = 6'(31 - i);
    end
    return n;
  endfunction

  // leading zero count of a 53-bit mantissa
  function automatic logic [5:0] lzc53(logic [52:0] x);
    logic [5:0] n;
    n = 6'd53;
    for (int i = 0; i < 53; i++) begin
      if (x[i]) n = 6'(52 - i);
    end
    return n;
  endfunction

endpackage

// ===== src/rwvd_if.sv =====
interface rwvd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  data_type;
  logic [15:0] word0;
  logic [15:0] word1;
  logic [15:0] word2;
  logic [15:0] word3;
  logic [2:0]  word_count;
  logic [63:0] scale_bits;
  logic        scale_enable;

  modport source (output valid, data_type, word0, word1, word2, word3, word_count,
                  scale_bits, scale_enable, input ready);
  modport sink (input valid, data_type, word0, word1, word2, word3, word_count,
                scale_bits, scale_enable, output ready);
endinterface

interface rwvd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value_bits;
  logic        error;

  modport source (output valid, value_bits, error, input ready);
  modport sink (input valid, value_bits, error, output ready);
endinterface

// ===== src/rwvd_front.sv =====
module rwvd_front
  import rwvd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  rwvd_in_if.sink    in_ch,
  output rwvd_item_t item,
  output logic       item_valid,
  input  logic       item_ready
);

  rwvd_item_t item_r, item_nxt;
  logic       valid_r, valid_nxt;

  // convert a sign and 32-bit magnitude to double
  function automatic logic [63:0] int_to_dbl(logic sgn, logic [31:0] mag);
    logic [5:0]  lz;
    logic [31:0] norm;
    lz   = lzc32(mag);
    norm = mag << lz;
    if (mag == 32'd0) return 64'd0;
    return {sgn, 11'(11'd1054 - {5'd0, lz}), norm[30:0], 21'd0};
  endfunction

  // widen single to double, subnormals normalized
  function automatic logic [63:0] flt_to_dbl(logic [31:0] b);
    logic [7:0]  e8;
    logic [22:0] f;
    logic [5:0]  sh;
    logic [22:0] fn;
    e8 = b[30:23];
    f  = b[22:0];
    sh = 6'(lzc32({f, 9'd0}) + 6'd1);
    fn = 23'(f << sh);
    if (e8 == 8'hFF) return {b[31], EXP_ALL_ONES, f, 29'd0};
    if (e8 == 8'd0) begin
      if (f == 23'd0) return {b[31], 63'd0};
      return {b[31], 11'(11'd897 - {5'd0, sh}), fn, 29'd0};
    end
    return {b[31], 11'({3'd0, e8} + 11'd896), f, 29'd0};
  endfunction

  // decode the register words
  always_comb begin
    logic [2:0]  cnt;
    logic [31:0] b32;
    logic [15:0] neg16;
    logic [31:0] neg32;
    cnt   = (in_ch.word_count > 3'd4) ? 3'd4 : in_ch.word_count;
    b32   = {in_ch.word0, in_ch.word1};
    neg16 = 16'(~in_ch.word0 + 16'd1);
    neg32 = 32'(~b32 + 32'd1);
    item_nxt.scale_enable = in_ch.scale_enable;
    item_nxt.scale_bits   = in_ch.scale_bits;
    item_nxt.value_bits   = 64'd0;
    item_nxt.err          = 1'b0;
    unique case (in_ch.data_type)
      TYPE_U16: begin
        item_nxt.err        = (cnt < 3'd1);
        item_nxt.value_bits = int_to_dbl(1'b0, {16'd0, in_ch.word0});
      end
      TYPE_S16: begin
        item_nxt.err        = (cnt < 3'd1);
        item_nxt.value_bits = in_ch.word0[15] ? int_to_dbl(1'b1, {16'd0, neg16})
                                              : int_to_dbl(1'b0, {16'd0, in_ch.word0});
      end
      TYPE_U32: begin
        item_nxt.err        = (cnt < 3'd2);
        item_nxt.value_bits = int_to_dbl(1'b0, b32);
      end
      TYPE_S32: begin
        item_nxt.err        = (cnt < 3'd2);
        item_nxt.value_bits = b32[31] ? int_to_dbl(1'b1, neg32) : int_to_dbl(1'b0, b32);
      end
      TYPE_F32: begin
        item_nxt.err        = (cnt < 3'd2);
        item_nxt.value_bits = flt_to_dbl(b32);
      end
      TYPE_F64: begin
        item_nxt.err        = (cnt < 3'd4);
        item_nxt.value_bits = {in_ch.word0, in_ch.word1, in_ch.word2, in_ch.word3};
      end
      default: item_nxt.err = 1'b1;
    endcase
  end

  assign in_ch.ready = !valid_r || item_ready;
  assign valid_nxt   = in_ch.ready ? in_ch.valid : valid_r;

  // hold the decoded request until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      item_r <= item_nxt;
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;

endmodule

// ===== src/rwvd_fifo.sv =====
module rwvd_fifo
  import rwvd_pkg::*;
#(
  parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  rwvd_item_t   push_item,
  input  logic         push_valid,
  output logic         push_ready,
  output rwvd_item_t   pop_item,
  output logic         pop_valid,
  input  logic         pop_ready,
  output rwvd_q_stat_t stat
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rwvd_item_t    mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  // advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
    if (push && !pop) count_nxt = CW'(count_r + 1'b1);
    if (pop && !push) count_nxt = CW'(count_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign stat.count = 8'(count_r);
  assign stat.full  = !push_ready;
  assign stat.empty = !pop_valid;

endmodule

// ===== src/rwvd_back.sv =====
module rwvd_back
  import rwvd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  rwvd_item_t item,
  input  logic       item_valid,
  output logic       item_ready,
  rwvd_out_if.source out_ch
);

  // stage 1: normalized operands
  rwvd_item_t         it1_r, it2_r, it3_r, it4_r;
  logic [52:0]        ma1_r, mb1_r;
  logic signed [13:0] ea1_r, eb1_r;
  logic               sgn1_r, sgn2_r, sgn3_r, sgn4_r;
  logic               zero1_r, zero2_r, zero3_r, zero4_r;
  // stage 2: partial products
  logic [51:0]        pp_hh_r;
  logic [52:0]        pp_hl_r, pp_lh_r;
  logic [53:0]        pp_ll_r;
  logic signed [13:0] e2_r, e3_r;
  // stage 3: full product
  logic [105:0]       prod3_r;
  // stage 4: aligned mantissa
  logic [10:0]        expf4_r;
  logic [51:0]        frac4_r;
  logic               g4_r, st4_r, ovf4_r;
  // output register
  logic [63:0]        value5_r, value5_nxt;
  logic               err5_r, err5_nxt;
  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  logic               en;

  assign en         = !v5_r || out_ch.ready;
  assign item_ready = en;

  // valid bits move as one pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= item_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // unpack and normalize both operands
  always_ff @(posedge clk) begin
    logic [52:0] ma, mb;
    logic [10:0] ea, eb;
    logic [5:0]  lza, lzb;
    if (en) begin
      ea  = (item.value_bits[62:52] == 11'd0) ? 11'd1 : item.value_bits[62:52];
      eb  = (item.scale_bits[62:52] == 11'd0) ? 11'd1 : item.scale_bits[62:52];
      ma  = {item.value_bits[62:52] != 11'd0, item.value_bits[51:0]};
      mb  = {item.scale_bits[62:52] != 11'd0, item.scale_bits[51:0]};
      lza = lzc53(ma);
      lzb = lzc53(mb);
      it1_r   <= item;
      ma1_r   <= ma << lza;
      mb1_r   <= mb << lzb;
      ea1_r   <= $signed({3'd0, ea}) - $signed({8'd0, lza});
      eb1_r   <= $signed({3'd0, eb}) - $signed({8'd0, lzb});
      sgn1_r  <= item.value_bits[63] ^ item.scale_bits[63];
      zero1_r <= (ma == 53'd0) || (mb == 53'd0);
    end
  end

  // split mantissas 26/27 and multiply
  always_ff @(posedge clk) begin
    if (en) begin
      it2_r   <= it1_r;
      sgn2_r  <= sgn1_r;
      zero2_r <= zero1_r;
      pp_hh_r <= ma1_r[52:27] * mb1_r[52:27];
      pp_hl_r <= ma1_r[52:27] * mb1_r[26:0];
      pp_lh_r <= ma1_r[26:0] * mb1_r[52:27];
      pp_ll_r <= ma1_r[26:0] * mb1_r[26:0];
      e2_r    <= ea1_r + eb1_r - 14'sd1023;
    end
  end

  // sum partial products
  always_ff @(posedge clk) begin
    if (en) begin
      it3_r   <= it2_r;
      sgn3_r  <= sgn2_r;
      zero3_r <= zero2_r;
      e3_r    <= e2_r;
      prod3_r <= ({54'd0, pp_hh_r} << 54) + ({52'd0, 54'(pp_hl_r) + 54'(pp_lh_r)} << 27)
               + {52'd0, pp_ll_r};
    end
  end

  // normalize product, shift into subnormal range, collect sticky
  always_ff @(posedge clk) begin
    logic signed [13:0] ex;
    logic signed [13:0] sh;
    logic [5:0]         shc;
    logic [52:0]        m;
    logic               g, st, lost;
    logic [55:0]        w, ws;
    if (en) begin
      ex = e3_r + $signed({13'd0, prod3_r[105]});
      if (prod3_r[105]) begin
        m  = prod3_r[105:53];
        g  = prod3_r[52];
        st = |prod3_r[51:0];
      end else begin
        m  = prod3_r[104:52];
        g  = prod3_r[51];
        st = |prod3_r[50:0];
      end
      sh   = 14'sd1 - ex;
      shc  = (ex > 14'sd0) ? 6'd0 : ((sh > 14'sd63) ? 6'd63 : 6'(sh));
      w    = {m, g, 2'b00};
      ws   = w >> shc;
      lost = |(w & ~({56{1'b1}} << shc));
      it4_r   <= it3_r;
      sgn4_r  <= sgn3_r;
      zero4_r <= zero3_r;
      expf4_r <= (ex > 14'sd0) ? 11'(ex) : 11'd0;
      ovf4_r  <= (ex > 14'sd2046);
      frac4_r <= ws[54:3];
      g4_r    <= ws[2];
      st4_r   <= st | ws[1] | ws[0] | lost;
    end
  end

  // round to nearest even, pack and select the result
  always_comb begin
    logic        inc, nfv, nfs, ovf;
    logic [62:0] packed_v;
    logic [63:0] prod;
    inc      = g4_r & (st4_r | frac4_r[0]);
    packed_v = {expf4_r, frac4_r} + {62'd0, inc};
    ovf      = !zero4_r && (ovf4_r || (packed_v[62:52] == EXP_ALL_ONES));
    prod     = zero4_r ? {sgn4_r, 63'd0} : {sgn4_r, packed_v};
    nfv      = (it4_r.value_bits[62:52] == EXP_ALL_ONES);
    nfs      = (it4_r.scale_bits[62:52] == EXP_ALL_ONES);
    err5_nxt = it4_r.err || nfv || (it4_r.scale_enable && (nfs || ovf));
    if (err5_nxt) value5_nxt = 64'd0;
    else if (it4_r.scale_enable) value5_nxt = prod;
    else value5_nxt = it4_r.value_bits;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value5_r <= value5_nxt;
      err5_r   <= err5_nxt;
    end
  end

  assign out_ch.valid      = v5_r;
  assign out_ch.value_bits = value5_r;
  assign out_ch.error      = err5_r;

endmodule

// ===== src/register_word_value_decoder.sv =====
// Register word value decoder.
// in_ch carries one request per handshake (valid and ready high at a rising
// edge): a type code, four big-endian register words, a word count and an
// optional double scale. out_ch returns one result per request, in order:
// the double bit pattern and an error flag (value zero on error).
// Throughput is one request per cycle while out_ch.ready stays high. From
// input acceptance to the result showing on out_ch, with an empty queue, a
// request passes the decode register, which loads at the accepting edge, the
// queue write, and the multiply pipeline (four stages and the output register),
// built around its two-step 53x53 mantissa product and rounding.
// A stalled receiver freezes the multiply pipeline; the queue and the decode
// register then absorb up to DEPTH+1 further requests before in_ch.ready
// drops. Reset (rst_n low, synchronous) empties the queue and pipeline;
// no request is lost or repeated across a stall.
module register_word_value_decoder
  import rwvd_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rwvd_in_if.sink    in_ch,
  rwvd_out_if.source out_ch
);

  rwvd_item_t   f_item, q_item;
  logic         f_valid, f_ready, q_valid, q_ready;
  rwvd_q_stat_t q_stat;

  rwvd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item       (f_item),
    .item_valid (f_valid),
    .item_ready (f_ready)
  );

  rwvd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_item  (f_item),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_item   (q_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .stat       (q_stat)
  );

  rwvd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (q_item),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .out_ch     (out_ch)
  );

  // error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.error |-> out_ch.value_bits == 64'd0)
    else $error("error result with nonzero value");

  // queue never holds more than its depth
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= 8'(FIFO_DEPTH))
    else $error("queue overfilled");

  // full and empty never both set
  a_q_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue flags inconsistent");

  // no result right after reset
  a_rst_out: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("result valid after reset");

endmodule
